@@ src/gltt_pkg.sv @@
package gltt_pkg;

  // Fixed field widths of the channels
  localparam int COORD_W = 13;
  localparam int TILE_W  = 5;
  localparam int INDEX_W = 10;
  localparam int GW_W    = 6;

  // Defaults of the top-level parameters
  localparam int GRID_SIZE_DEF = 32;
  localparam int FRAC_BITS_DEF = 8;

  // Grid width after reset
  localparam logic [GW_W-1:0] GW_RESET = 6'd32;

  // One segment: start and end points in unsigned fixed point
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  // One visited tile
  typedef struct packed {
    logic [INDEX_W-1:0] tile_index;
    logic [TILE_W-1:0]  tile_col;
    logic [TILE_W-1:0]  tile_row;
    logic               last;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul_x;
    logic mul_y;
    logic step;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

@@ src/gltt_ctrl.sv @@
module gltt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  gltt_pkg::dp_sts_t sts,
  output gltt_pkg::dp_cmd_t cmd
);

  gltt_pkg::state_t state_r;
  gltt_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gltt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands: load, two setup products, then one tile per beat
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      gltt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = gltt_pkg::ST_MUL_X;
        end
      end
      gltt_pkg::ST_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_nxt = gltt_pkg::ST_MUL_Y;
      end
      gltt_pkg::ST_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = gltt_pkg::ST_EMIT;
      end
      gltt_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = gltt_pkg::ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = gltt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/gltt_dp.sv @@
module gltt_dp #(
  parameter int GRID_SIZE = gltt_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = gltt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gltt_pkg::in_item_t            in_item,
  input  logic                          cfg_we,
  input  logic [gltt_pkg::GW_W-1:0]     cfg_data,
  input  gltt_pkg::dp_cmd_t             cmd,
  output gltt_pkg::dp_sts_t             sts,
  output gltt_pkg::out_item_t           out_item
);

  localparam int COORD_W = gltt_pkg::COORD_W;
  localparam int TILE_W  = gltt_pkg::TILE_W;
  localparam int GW_W    = gltt_pkg::GW_W;
  localparam int INDEX_W = gltt_pkg::INDEX_W;
  localparam int NF_W    = FRAC_BITS + 1;
  localparam int P_W     = NF_W + COORD_W;
  localparam int T_W     = COORD_W + ((COORD_W > FRAC_BITS) ? COORD_W : FRAC_BITS) + 2;
  localparam int CNT_W   = $clog2(2 * GRID_SIZE);
  localparam int IDX_W   = TILE_W + GW_W;
  localparam int unsigned COORD_MAX = (GRID_SIZE << FRAC_BITS) - 1;
  localparam int unsigned FRAC_MASK = (1 << FRAC_BITS) - 1;
  localparam logic [NF_W-1:0]  ONE_TILE = NF_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(2 * GRID_SIZE - 2);

  // Saturate a coordinate to the grid
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] c;
    c = v;
    if (32'(v) > COORD_MAX) begin
      c = COORD_W'(COORD_MAX);
    end
    return c;
  endfunction

  logic [GW_W-1:0]    gw_r;
  logic [TILE_W-1:0]  x_r, y_r, endx_r, endy_r;
  logic [COORD_W-1:0] adx_r, ady_r;
  logic               neg_x_r, neg_y_r;
  logic [NF_W-1:0]    nxf_r, nyf_r;
  logic [T_W-1:0]     tx_r, ty_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [NF_W-1:0]    fx, fy;
  logic [NF_W-1:0]    mul_a;
  logic [COORD_W-1:0] mul_b;
  logic [P_W-1:0]     prod;
  logic               x_done, y_done, at_end;
  logic               mx, my;
  logic [IDX_W-1:0]   idx_full;

  // Grid width register, written from the configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= gltt_pkg::GW_RESET;
    end else if (cfg_we) begin
      gw_r <= cfg_data;
    end
  end

  // Saturated start and end points and the fraction parts of the start point
  always_comb begin
    sx = clamp_coord(in_item.start_x);
    sy = clamp_coord(in_item.start_y);
    ex = clamp_coord(in_item.end_x);
    ey = clamp_coord(in_item.end_y);
    fx = NF_W'(32'(sx) & FRAC_MASK);
    fy = NF_W'(32'(sy) & FRAC_MASK);
  end

  // One shared multiplier forms the two initial crossing products
  always_comb begin
    mul_a = cmd.mul_x ? nxf_r : nyf_r;
    mul_b = cmd.mul_x ? ady_r : adx_r;
    prod  = P_W'(mul_a) * P_W'(mul_b);
  end

  // Step decision: an axis at its end tile stays; otherwise the earlier boundary wins, and a tie steps both
  always_comb begin
    x_done = (x_r == endx_r);
    y_done = (y_r == endy_r);
    at_end = x_done && y_done;
    if (x_done) begin
      mx = 1'b0;
      my = 1'b1;
    end else if (y_done) begin
      mx = 1'b1;
      my = 1'b0;
    end else begin
      mx = (tx_r <= ty_r);
      my = (ty_r <= tx_r);
    end
  end

  // Segment setup and tile walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= TILE_W'(sx >> FRAC_BITS);
      y_r     <= TILE_W'(sy >> FRAC_BITS);
      endx_r  <= TILE_W'(ex >> FRAC_BITS);
      endy_r  <= TILE_W'(ey >> FRAC_BITS);
      neg_x_r <= !(ex > sx);
      neg_y_r <= !(ey > sy);
      adx_r   <= (ex > sx) ? (ex - sx) : (sx - ex);
      ady_r   <= (ey > sy) ? (ey - sy) : (sy - ey);
      nxf_r   <= (ex > sx) ? (ONE_TILE - fx) : fx;
      nyf_r   <= (ey > sy) ? (ONE_TILE - fy) : fy;
    end
    if (cmd.mul_x) begin
      tx_r <= T_W'(prod);
    end
    if (cmd.mul_y) begin
      ty_r <= T_W'(prod);
    end
    if (cmd.step) begin
      if (mx) begin
        x_r  <= neg_x_r ? TILE_W'(x_r - 1'b1) : TILE_W'(x_r + 1'b1);
        tx_r <= tx_r + (T_W'(ady_r) << FRAC_BITS);
      end
      if (my) begin
        y_r  <= neg_y_r ? TILE_W'(y_r - 1'b1) : TILE_W'(y_r + 1'b1);
        ty_r <= ty_r + (T_W'(adx_r) << FRAC_BITS);
      end
    end
  end

  // Count of tiles emitted in this run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Result beat built from the current tile
  always_comb begin
    idx_full            = IDX_W'(y_r) * IDX_W'(gw_r) + IDX_W'(x_r);
    out_item.tile_index = INDEX_W'(idx_full);
    out_item.tile_col   = x_r;
    out_item.tile_row   = y_r;
    out_item.last       = at_end || (cnt_r == LAST_CNT);
    sts.last            = out_item.last;
  end

endmodule

@@ src/grid_line_tile_traversal_top.sv @@
// Grid line tile traversal. Each input beat is one segment, given by start and end
// points in unsigned fixed point; the block returns, in order, one beat per grid tile
// that the segment crosses, from the start tile to the end tile, with last set on the
// final beat. Corner hits step both axes at once. The block works on one segment at a
// time: after a segment is accepted, the MUL_X and MUL_Y states form the initial crossing
// products on a single shared multiplier, and then the walk produces one tile per cycle
// while the result side does not stall. A segment has 1 to 2*GRID_SIZE-1 tiles, and the
// next segment is accepted only after the last beat of the current one has been taken.
// The row width register may be written whenever no segment is in flight.
module grid_line_tile_traversal_top #(
  parameter int GRID_SIZE = gltt_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = gltt_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  gltt_pkg::in_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output gltt_pkg::out_item_t       out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gltt_pkg::GW_W-1:0] cfg_data
);

  gltt_pkg::dp_cmd_t cmd;
  gltt_pkg::dp_sts_t sts;

  // The register port always takes a beat
  assign cfg_ready = 1'b1;

  gltt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gltt_dp #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // No segment is taken while tiles are being delivered.
  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("segment accepted during a walk");

  // The first tile appears once the MUL_X and MUL_Y states have followed the acceptance of a segment.
  a_first_tile: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##3 out_valid)
    else $error("first tile not presented on time");

  // The run ends after the beat flagged last.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_item.last) |=> !out_valid)
    else $error("tiles continue after the last beat");

  // Every tile lies inside the grid.
  a_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.tile_col) < GRID_SIZE && 32'(out_item.tile_row) < GRID_SIZE))
    else $error("tile outside the grid");

endmodule
